@@ rtl/core/akf_pkg.sv @@
// Shared types and constants for the altitude Kalman filter unit.
// Holds the sequencer state type, the step micro-code and the fixed-point
// constants; used by the top-level module of the block.
package akf_pkg;

    // Fixed-point constants in Q24.24, at most 64 bits wide.
    localparam logic [63:0] ONE_Q24   = 64'd16777216;
    localparam logic [63:0] TENTH_Q24 = 64'd1677722;
    localparam logic [63:0] TEN_Q24   = 64'd167772160;

    // Configuration register reset values, unsigned Q16.16.
    localparam logic [31:0] R_RESET = 32'd393216;
    localparam logic [31:0] Q_RESET = 32'd327680;

    // Configuration register indexes.
    localparam logic CFG_MEAS_NOISE = 1'b0;
    localparam logic CFG_PROC_NOISE = 1'b1;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT,
        ST_FINISH,
        ST_OUTPUT
    } state_t;

    // Operations of the shared datapath.
    typedef enum logic [1:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV
    } op_t;

    // Operand and destination selectors.
    typedef enum logic [4:0] {
        RS_ALT, RS_VEL, RS_C00, RS_C01, RS_C10, RS_C11,
        RS_MEAS, RS_DT, RS_RQ, RS_QQ, RS_HP,
        RS_P00, RS_P01, RS_P10, RS_P11,
        RS_Y, RS_S, RS_K0, RS_K1, RS_T,
        RS_TENTH, RS_ONE
    } rsel_t;

    typedef struct packed {
        op_t   op;
        rsel_t dst;
        rsel_t src_a;
        rsel_t src_b;
    } step_t;

    localparam int         N_STEPS   = 29;
    localparam logic [4:0] LAST_STEP = 5'd28;

    // Micro-code: one filter iteration as a list of two-operand steps.
    function automatic step_t akf_step_decode(input logic [4:0] idx);
        step_t s;
        s = '{OP_ADD, RS_T, RS_T, RS_T};
        unique case (idx)
            5'd0:  s = '{OP_MUL, RS_T,   RS_VEL,  RS_DT};
            5'd1:  s = '{OP_ADD, RS_HP,  RS_ALT,  RS_T};
            5'd2:  s = '{OP_ADD, RS_T,   RS_C10,  RS_C01};
            5'd3:  s = '{OP_MUL, RS_T,   RS_DT,   RS_T};
            5'd4:  s = '{OP_ADD, RS_P00, RS_C00,  RS_T};
            5'd5:  s = '{OP_MUL, RS_T,   RS_DT,   RS_DT};
            5'd6:  s = '{OP_MUL, RS_T,   RS_T,    RS_C11};
            5'd7:  s = '{OP_ADD, RS_P00, RS_P00,  RS_T};
            5'd8:  s = '{OP_ADD, RS_P00, RS_P00,  RS_QQ};
            5'd9:  s = '{OP_MUL, RS_T,   RS_DT,   RS_C11};
            5'd10: s = '{OP_ADD, RS_P01, RS_C01,  RS_T};
            5'd11: s = '{OP_ADD, RS_P10, RS_C10,  RS_T};
            5'd12: s = '{OP_MUL, RS_T,   RS_QQ,   RS_TENTH};
            5'd13: s = '{OP_ADD, RS_P11, RS_C11,  RS_T};
            5'd14: s = '{OP_SUB, RS_Y,   RS_MEAS, RS_HP};
            5'd15: s = '{OP_ADD, RS_S,   RS_P00,  RS_RQ};
            5'd16: s = '{OP_DIV, RS_K0,  RS_P00,  RS_S};
            5'd17: s = '{OP_DIV, RS_K1,  RS_P10,  RS_S};
            5'd18: s = '{OP_MUL, RS_T,   RS_K0,   RS_Y};
            5'd19: s = '{OP_ADD, RS_ALT, RS_HP,   RS_T};
            5'd20: s = '{OP_MUL, RS_T,   RS_K1,   RS_Y};
            5'd21: s = '{OP_ADD, RS_VEL, RS_VEL,  RS_T};
            5'd22: s = '{OP_SUB, RS_T,   RS_ONE,  RS_K0};
            5'd23: s = '{OP_MUL, RS_C00, RS_T,    RS_P00};
            5'd24: s = '{OP_MUL, RS_C01, RS_T,    RS_P01};
            5'd25: s = '{OP_MUL, RS_T,   RS_K1,   RS_P00};
            5'd26: s = '{OP_SUB, RS_C10, RS_P10,  RS_T};
            5'd27: s = '{OP_MUL, RS_T,   RS_K1,   RS_P01};
            5'd28: s = '{OP_SUB, RS_C11, RS_P11,  RS_T};
            default: s = '{OP_ADD, RS_T, RS_T, RS_T};
        endcase
        return s;
    endfunction

endpackage

@@ rtl/core/akf_mul.sv @@
// Iterative signed Q24.24 multiplier for the altitude Kalman filter unit.
// Forms the product from 32x32 partial products, rounds and saturates.
// Depends on nothing but its parameter.
module akf_mul #(
    parameter int W = 48
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic signed [W-1:0] op_a,
    input  logic signed [W-1:0] op_b,
    output logic signed [W-1:0] result,
    output logic                clip,
    output logic                done
);
    localparam int NCH = (W + 31) / 32;
    localparam int NPP = NCH * NCH;
    localparam int PW  = NCH * 32;
    localparam int AW  = 2 * PW;
    localparam int CW  = $clog2(NPP + 2) + 1;
    localparam logic [AW-1:0] LIM_POS  = (AW'(1) << (W - 1)) - AW'(1);
    localparam logic [AW-1:0] LIM_NEG  = AW'(1) << (W - 1);
    localparam logic [AW-1:0] HALF_LSB = AW'(1) << 23;

    logic [PW-1:0]  a_mag_reg, b_mag_reg;
    logic           neg_reg;
    logic [AW-1:0]  acc_reg;
    logic [63:0]    pp_reg;
    logic [CW-1:0]  sh_reg;
    logic           pp_vld_reg;
    logic [CW-1:0]  cnt_reg;
    logic           busy_reg;
    logic [W-1:0]   result_reg;
    logic           clip_reg;
    logic           done_reg;

    logic [W-1:0]   a_abs, b_abs;
    logic [CW-1:0]  ai, bj;
    logic [31:0]    a_chunk, b_chunk;
    logic [AW-1:0]  rnd, rm;
    logic [W-1:0]   fin_val;
    logic           fin_clip;

    // Operand magnitudes; the most negative value maps to its true magnitude.
    assign a_abs = op_a[W-1] ? W'(-op_a) : W'(op_a);
    assign b_abs = op_b[W-1] ? W'(-op_b) : W'(op_b);

    // Chunk selection for the current partial product.
    assign ai      = CW'(cnt_reg / NCH);
    assign bj      = CW'(cnt_reg % NCH);
    assign a_chunk = 32'(a_mag_reg >> (32 * ai));
    assign b_chunk = 32'(b_mag_reg >> (32 * bj));

    // Rounding to nearest, ties away from zero, then saturation.
    always_comb begin
        rnd      = acc_reg + HALF_LSB;
        rm       = rnd >> 24;
        fin_clip = 1'b0;
        if (neg_reg) begin
            if (rm > LIM_NEG) begin
                fin_clip = 1'b1;
                fin_val  = W'(LIM_NEG);
            end else begin
                fin_val = W'(-rm);
            end
        end else begin
            if (rm > LIM_POS) begin
                fin_clip = 1'b1;
                fin_val  = W'(LIM_POS);
            end else begin
                fin_val = W'(rm);
            end
        end
    end

    // Control of the partial-product sequence.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg   <= 1'b0;
            done_reg   <= 1'b0;
            pp_vld_reg <= 1'b0;
            cnt_reg    <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg   <= 1'b1;
                pp_vld_reg <= 1'b0;
                cnt_reg    <= '0;
            end else if (busy_reg) begin
                pp_vld_reg <= (cnt_reg < CW'(NPP));
                cnt_reg    <= cnt_reg + CW'(1);
                if (cnt_reg == CW'(NPP + 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Operand capture, partial products and accumulation.
    always_ff @(posedge aclk) begin
        if (start) begin
            a_mag_reg <= PW'(a_abs);
            b_mag_reg <= PW'(b_abs);
            neg_reg   <= op_a[W-1] ^ op_b[W-1];
            acc_reg   <= '0;
        end else if (busy_reg) begin
            pp_reg <= 64'(a_chunk) * 64'(b_chunk);
            sh_reg <= ai + bj;
            if (pp_vld_reg) begin
                acc_reg <= acc_reg + (AW'(pp_reg) << (32 * sh_reg));
            end
            if (cnt_reg == CW'(NPP + 1)) begin
                result_reg <= fin_val;
                clip_reg   <= fin_clip;
            end
        end
    end

    assign result = result_reg;
    assign clip   = clip_reg;
    assign done   = done_reg;

endmodule

@@ rtl/core/akf_div.sv @@
// Bit-serial signed Q24.24 divider for the altitude Kalman filter unit.
// Restoring division of (|n| << 24) by |d|, one quotient bit per cycle,
// with sign and saturation applied at the end; depends on nothing else.
module akf_div #(
    parameter int W = 48
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic signed [W-1:0] op_n,
    input  logic signed [W-1:0] op_d,
    output logic signed [W-1:0] result,
    output logic                clip,
    output logic                done
);
    localparam int NW = W + 24;
    localparam int CW = $clog2(NW + 1) + 1;
    localparam logic [NW-1:0] LIM_POS = (NW'(1) << (W - 1)) - NW'(1);
    localparam logic [NW-1:0] LIM_NEG = NW'(1) << (W - 1);

    logic [NW-1:0] num_reg;
    logic [W-1:0]  d_reg;
    logic [W-1:0]  rem_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          fin_reg;
    logic          neg_reg;
    logic [W-1:0]  result_reg;
    logic          clip_reg;
    logic          done_reg;

    logic [W-1:0]  n_abs, d_abs;
    logic [W:0]    rem_sh;
    logic          ge;
    logic [W-1:0]  fin_val;
    logic          fin_clip;

    assign n_abs = op_n[W-1] ? W'(-op_n) : W'(op_n);
    assign d_abs = op_d[W-1] ? W'(-op_d) : W'(op_d);

    // One restoring step.
    assign rem_sh = {rem_reg, num_reg[NW-1]};
    assign ge     = (rem_sh >= {1'b0, d_reg});

    // Sign and saturation of the finished quotient.
    always_comb begin
        fin_clip = 1'b0;
        if (neg_reg) begin
            if (num_reg > LIM_NEG) begin
                fin_clip = 1'b1;
                fin_val  = W'(LIM_NEG);
            end else begin
                fin_val = W'(-num_reg);
            end
        end else begin
            if (num_reg > LIM_POS) begin
                fin_clip = 1'b1;
                fin_val  = W'(LIM_POS);
            end else begin
                fin_val = W'(num_reg);
            end
        end
    end

    // Sequence control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            fin_reg  <= 1'b0;
            if (start) begin
                cnt_reg <= '0;
                if (op_d == '0) begin
                    done_reg <= 1'b1;
                end else begin
                    busy_reg <= 1'b1;
                end
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CW'(1);
                if (cnt_reg == CW'(NW - 1)) begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end else if (fin_reg) begin
                done_reg <= 1'b1;
            end
        end
    end

    // Datapath: a zero divisor gives a zero quotient without iterating.
    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg    <= {n_abs, 24'd0};
            d_reg      <= d_abs;
            rem_reg    <= '0;
            neg_reg    <= op_n[W-1] ^ op_d[W-1];
            result_reg <= '0;
            clip_reg   <= 1'b0;
        end else if (busy_reg) begin
            rem_reg <= ge ? W'(rem_sh - {1'b0, d_reg}) : W'(rem_sh);
            num_reg <= {num_reg[NW-2:0], ge};
        end else if (fin_reg) begin
            result_reg <= fin_val;
            clip_reg   <= fin_clip;
        end
    end

    assign result = result_reg;
    assign clip   = clip_reg;
    assign done   = done_reg;

endmodule

@@ rtl/core/altitude_kalman_filter_unit.sv @@
// Altitude Kalman filter unit: two-state constant-velocity filter.
// Sequencer, state registers and adder; uses akf_pkg, akf_mul and akf_div.
//
// Usage: the input channel (s_) carries one barometric altitude sample and
// the time step since the previous sample. Each accepted item produces one
// result item on the output channel (m_) with the filtered altitude and
// vertical velocity in Q20.12, and a saturation flag in m_tuser.
// The two noise variances R and Q are to be written on the cfg_ port only
// while idle; the block itself does not enforce this. The working time of
// an item is set by the bit-serial divider, used twice per item, and by the
// twelve passes through the shared 32x32 multiplier; it is shorter when a
// divisor is zero. One item is in work at a time: s_tready is high only
// while the unit is idle.
// Reset (aresetn low, synchronous) clears the estimates to zero, sets both
// variances to 10.0 and the noise registers to R = 6.0 and Q = 5.0.
// When the receiver stalls the result item is held on m_ until taken, and no
// new item is accepted meanwhile.
module altitude_kalman_filter_unit #(
    parameter int STATE_WIDTH = 48
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input item.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // [31:0] measured_altitude, [51:32] time_step
    // Result item.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [31:0] altitude_estimate, [63:32] velocity_estimate
    output logic [0:0]  m_tuser,   // [0] saturated
    // Configuration writes.
    input  logic        cfg_wr_en,
    input  logic        cfg_addr,
    input  logic [31:0] cfg_wdata
);
    import akf_pkg::*;

    localparam int W = STATE_WIDTH;
    localparam logic signed [W-1:0] LIM_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] LIM_MIN = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [64:0]  LIM_MAX_X = (65'sd1 <<< (W - 1)) - 65'sd1;
    localparam logic signed [64:0]  LIM_MIN_X = -(65'sd1 <<< (W - 1));
    localparam logic signed [W:0]   O_MAX = (W+1)'(65'sd2147483647);
    localparam logic signed [W:0]   O_MIN = (W+1)'(-65'sd2147483648);
    localparam logic signed [W:0]   O_HALF = (W+1)'(65'sd2048);

    typedef struct packed {
        logic load;
        logic wb;
        logic adv;
        logic mul_start;
        logic div_start;
        logic finish;
    } ctrl_t;

    state_t state_reg, state_next;
    logic [4:0] step_reg;
    ctrl_t ctrl;

    // Configuration registers.
    logic [31:0] r_noise_reg, q_noise_reg;

    // Filter state and per-item working registers.
    logic signed [W-1:0] alt_reg, vel_reg, c00_reg, c01_reg, c10_reg, c11_reg;
    logic signed [W-1:0] meas_reg, dt_reg, rq_reg, qq_reg, hp_reg;
    logic signed [W-1:0] p00_reg, p01_reg, p10_reg, p11_reg;
    logic signed [W-1:0] y_reg, s_reg, k0_reg, k1_reg, t_reg;
    logic                sat_reg;
    logic [63:0]         out_data_reg;
    logic                out_sat_reg;

    step_t               dec;
    logic signed [W-1:0] opa, opb;
    logic signed [W:0]   sum;
    logic signed [W-1:0] add_val;
    logic                add_clip;
    logic signed [W-1:0] mul_res, div_res;
    logic                mul_clip, div_clip, mul_done, div_done;
    logic                unit_done;
    logic signed [W-1:0] wb_val;
    logic                wb_clip;
    logic [W:0]          meas_cl, dt_cl, rq_cl, qq_cl;
    logic [32:0]         alt_out, vel_out;

    // Clamp a wide signed value to the state width; top bit is the clip flag.
    function automatic logic [W:0] clamp_w(input logic signed [64:0] v);
        logic [W:0] r;
        if (v > LIM_MAX_X) begin
            r = {1'b1, LIM_MAX};
        end else if (v < LIM_MIN_X) begin
            r = {1'b1, LIM_MIN};
        end else begin
            r = {1'b0, v[W-1:0]};
        end
        return r;
    endfunction

    // Q24.24 to Q20.12, ties toward plus infinity, clipped to 32 bits.
    function automatic logic [32:0] to_q12(input logic signed [W-1:0] x);
        logic signed [W:0] v;
        logic signed [W:0] q;
        logic [32:0]       r;
        v = {x[W-1], x} + O_HALF;
        q = v >>> 12;
        if (q > O_MAX) begin
            r = {1'b1, 32'h7fffffff};
        end else if (q < O_MIN) begin
            r = {1'b1, 32'h80000000};
        end else begin
            r = {1'b0, q[31:0]};
        end
        return r;
    endfunction

    // Operand selection.
    function automatic logic signed [W-1:0] sel_op(input rsel_t s);
        logic signed [W-1:0] v;
        unique case (s)
            RS_ALT:   v = alt_reg;
            RS_VEL:   v = vel_reg;
            RS_C00:   v = c00_reg;
            RS_C01:   v = c01_reg;
            RS_C10:   v = c10_reg;
            RS_C11:   v = c11_reg;
            RS_MEAS:  v = meas_reg;
            RS_DT:    v = dt_reg;
            RS_RQ:    v = rq_reg;
            RS_QQ:    v = qq_reg;
            RS_HP:    v = hp_reg;
            RS_P00:   v = p00_reg;
            RS_P01:   v = p01_reg;
            RS_P10:   v = p10_reg;
            RS_P11:   v = p11_reg;
            RS_Y:     v = y_reg;
            RS_S:     v = s_reg;
            RS_K0:    v = k0_reg;
            RS_K1:    v = k1_reg;
            RS_T:     v = t_reg;
            RS_TENTH: v = W'(TENTH_Q24);
            RS_ONE:   v = W'(ONE_Q24);
            default:  v = '0;
        endcase
        return v;
    endfunction

    // Current micro-code step and its operands.
    assign dec = akf_step_decode(step_reg);

    always_comb begin
        opa = sel_op(dec.src_a);
        opb = sel_op(dec.src_b);
    end

    // Saturating adder and subtracter.
    always_comb begin
        if (dec.op == OP_SUB) begin
            sum = {opa[W-1], opa} - {opb[W-1], opb};
        end else begin
            sum = {opa[W-1], opa} + {opb[W-1], opb};
        end
        add_clip = sum[W] ^ sum[W-1];
        add_val  = add_clip ? (sum[W] ? LIM_MIN : LIM_MAX) : sum[W-1:0];
    end

    // Shared multiply and divide units.
    akf_mul #(.W(W)) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (ctrl.mul_start),
        .op_a    (opa),
        .op_b    (opb),
        .result  (mul_res),
        .clip    (mul_clip),
        .done    (mul_done)
    );

    akf_div #(.W(W)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (ctrl.div_start),
        .op_n    (opa),
        .op_d    (opb),
        .result  (div_res),
        .clip    (div_clip),
        .done    (div_done)
    );

    assign unit_done = (dec.op == OP_MUL) ? mul_done : div_done;

    // Write-back value for the current step.
    always_comb begin
        case (dec.op)
            OP_MUL: begin
                wb_val  = mul_res;
                wb_clip = mul_clip;
            end
            OP_DIV: begin
                wb_val  = div_res;
                wb_clip = div_clip;
            end
            default: begin
                wb_val  = add_val;
                wb_clip = add_clip;
            end
        endcase
    end

    // Widening of the input item and the noise registers into Q24.24.
    assign meas_cl = clamp_w($signed({{21{s_tdata[31]}}, s_tdata[31:0], 12'd0}));
    assign dt_cl   = clamp_w($signed({37'd0, s_tdata[51:32], 8'd0}));
    assign rq_cl   = clamp_w($signed({25'd0, r_noise_reg, 8'd0}));
    assign qq_cl   = clamp_w($signed({25'd0, q_noise_reg, 8'd0}));

    assign alt_out = to_q12(alt_reg);
    assign vel_out = to_q12(vel_reg);

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                if (dec.op == OP_MUL || dec.op == OP_DIV) begin
                    state_next = ST_WAIT;
                end else if (step_reg == LAST_STEP) begin
                    state_next = ST_FINISH;
                end
            end
            ST_WAIT: begin
                if (unit_done) begin
                    state_next = (step_reg == LAST_STEP) ? ST_FINISH : ST_ISSUE;
                end
            end
            ST_FINISH: begin
                state_next = ST_OUTPUT;
            end
            ST_OUTPUT: begin
                if (m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control outputs of the sequencer.
    always_comb begin
        ctrl     = '0;
        s_tready = 1'b0;
        m_tvalid = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready  = 1'b1;
                ctrl.load = s_tvalid;
            end
            ST_ISSUE: begin
                ctrl.mul_start = (dec.op == OP_MUL);
                ctrl.div_start = (dec.op == OP_DIV);
                ctrl.wb        = (dec.op == OP_ADD) || (dec.op == OP_SUB);
                ctrl.adv       = ctrl.wb;
            end
            ST_WAIT: begin
                ctrl.wb  = unit_done;
                ctrl.adv = unit_done;
            end
            ST_FINISH: begin
                ctrl.finish = 1'b1;
            end
            ST_OUTPUT: begin
                m_tvalid = 1'b1;
            end
            default: ctrl = '0;
        endcase
    end

    // Sequencer registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            if (ctrl.load) begin
                step_reg <= '0;
            end else if (ctrl.adv) begin
                step_reg <= step_reg + 5'd1;
            end
        end
    end

    // Configuration register writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r_noise_reg <= R_RESET;
            q_noise_reg <= Q_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_MEAS_NOISE: r_noise_reg <= cfg_wdata;
                CFG_PROC_NOISE: q_noise_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Filter state, reset to zero estimates and a diagonal covariance of 10.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alt_reg <= '0;
            vel_reg <= '0;
            c00_reg <= W'(TEN_Q24);
            c01_reg <= '0;
            c10_reg <= '0;
            c11_reg <= W'(TEN_Q24);
            sat_reg <= 1'b0;
        end else begin
            if (ctrl.load) begin
                sat_reg <= meas_cl[W] | dt_cl[W] | rq_cl[W] | qq_cl[W];
            end else if (ctrl.wb) begin
                sat_reg <= sat_reg | wb_clip;
            end
            if (ctrl.wb) begin
                case (dec.dst)
                    RS_ALT: alt_reg <= wb_val;
                    RS_VEL: vel_reg <= wb_val;
                    RS_C00: c00_reg <= wb_val;
                    RS_C01: c01_reg <= wb_val;
                    RS_C10: c10_reg <= wb_val;
                    RS_C11: c11_reg <= wb_val;
                    default: ;
                endcase
            end
        end
    end

    // Working registers for one item.
    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            meas_reg <= meas_cl[W-1:0];
            dt_reg   <= dt_cl[W-1:0];
            rq_reg   <= rq_cl[W-1:0];
            qq_reg   <= qq_cl[W-1:0];
        end
        if (ctrl.wb) begin
            case (dec.dst)
                RS_HP:  hp_reg  <= wb_val;
                RS_P00: p00_reg <= wb_val;
                RS_P01: p01_reg <= wb_val;
                RS_P10: p10_reg <= wb_val;
                RS_P11: p11_reg <= wb_val;
                RS_Y:   y_reg   <= wb_val;
                RS_S:   s_reg   <= wb_val;
                RS_K0:  k0_reg  <= wb_val;
                RS_K1:  k1_reg  <= wb_val;
                RS_T:   t_reg   <= wb_val;
                default: ;
            endcase
        end
        if (ctrl.finish) begin
            out_data_reg <= {vel_out[31:0], alt_out[31:0]};
            out_sat_reg  <= sat_reg | alt_out[32] | vel_out[32];
        end
    end

    assign m_tdata    = out_data_reg;
    assign m_tuser[0] = out_sat_reg;

endmodule

@@ rtl/core/akf_checker.sv @@
// Port-level checks for the altitude Kalman filter unit.
// Sees only the top level's ports; bound to altitude_kalman_filter_unit below.
module akf_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic [0:0]  m_tuser
);

    // A stalled result item holds its payload.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result item changed while stalled");

    // One item at a time: no input is taken while a result waits.
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input ready while a result is pending");

    // An accepted item leaves the unit busy, with the input closed and no result valid.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready && !m_tvalid)
        else $error("unit not busy after accepting an item");

    // A result that is taken leaves the unit idle and ready.
    a_idle_after_output: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready |=> s_tready && !m_tvalid)
        else $error("unit not idle after delivering a result");

endmodule

bind altitude_kalman_filter_unit akf_checker u_akf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

@@ test/akf_checker.sv @@
// Scoreboard for the altitude Kalman filter unit: it mirrors the filter in
// wide signed fixed point and checks every result item on the m_ channel.
// Depends on akf_pkg for the register indexes and the Q24.24 constants.
module akf_scoreboard (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [55:0] s_tdata,   // [31:0] measured_altitude, [51:32] time_step
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,   // [31:0] altitude_estimate, [63:32] velocity_estimate
    input  logic [0:0]  m_tuser,   // [0] saturated
    input  logic        cfg_wr_en,
    input  logic        cfg_addr,
    input  logic [31:0] cfg_wdata,
    output int          fail_count,
    output int          pending
);
    import akf_pkg::*;

    typedef logic signed [127:0] acc_t;

    typedef struct packed {
        logic [31:0] altitude;
        logic [31:0] velocity;
        logic        saturated;
    } estimate_t;

    localparam acc_t ST_MAX = (acc_t'(1) <<< 47) - 1;
    localparam acc_t ST_MIN = -(acc_t'(1) <<< 47);

    // Filter state, Q24.24 values that always fit 48 bits.
    acc_t alt_q, vel_q, c00, c01, c10, c11;
    logic [31:0] meas_noise, proc_noise;
    logic        clipped;
    estimate_t   estimate_fifo[$];

    function automatic acc_t clip48(acc_t x);
        if (x > ST_MAX) begin
            clipped = 1'b1;
            return ST_MAX;
        end
        if (x < ST_MIN) begin
            clipped = 1'b1;
            return ST_MIN;
        end
        return x;
    endfunction

    function automatic acc_t magnitude(acc_t a);
        return (a < 0) ? -a : a;
    endfunction

    // Q24.24 product, rounded half away from zero.
    function automatic acc_t qmult(acc_t a, acc_t b);
        acc_t m;
        m = (magnitude(a) * magnitude(b) + (acc_t'(1) <<< 23)) >>> 24;
        return clip48(((a < 0) != (b < 0)) ? -m : m);
    endfunction

    // Q24.24 quotient, truncated on magnitudes; a zero divisor gives zero gain.
    function automatic acc_t qdivide(acc_t n, acc_t d);
        acc_t m;
        if (d == 0) return 0;
        m = (magnitude(n) <<< 24) / magnitude(d);
        return clip48(((n < 0) != (d < 0)) ? -m : m);
    endfunction

    // Q24.24 to Q20.12, ties toward plus infinity, clipped to 32 bits.
    function automatic logic [31:0] to_q12(acc_t x);
        acc_t r;
        r = (x + 2048) >>> 12;
        if (r > 64'sd2147483647) begin
            clipped = 1'b1;
            r = 64'sd2147483647;
        end else if (r < -64'sd2147483648) begin
            clipped = 1'b1;
            r = -64'sd2147483648;
        end
        return r[31:0];
    endfunction

    // One filter iteration: predict, correct, update covariance.
    function automatic estimate_t predict_correct(logic [31:0] raw_alt, logic [19:0] raw_dt);
        acc_t meas, dt, rq, qq, hp, vp, p00, p01, p10, p11, y, s, k0, k1, omk;
        estimate_t e;
        clipped = 1'b0;
        meas = $signed(raw_alt);
        meas = clip48(meas * 4096);
        dt = clip48(acc_t'(raw_dt) * 256);
        rq = clip48(acc_t'(meas_noise) * 256);
        qq = clip48(acc_t'(proc_noise) * 256);

        hp = clip48(alt_q + qmult(vel_q, dt));
        vp = vel_q;
        p00 = clip48(c00 + qmult(dt, clip48(c10 + c01)));
        p00 = clip48(p00 + qmult(qmult(dt, dt), c11));
        p00 = clip48(p00 + qq);
        p01 = clip48(c01 + qmult(dt, c11));
        p10 = clip48(c10 + qmult(dt, c11));
        p11 = clip48(c11 + qmult(qq, acc_t'(TENTH_Q24)));

        y = clip48(meas - hp);
        s = clip48(p00 + rq);
        k0 = qdivide(p00, s);
        k1 = qdivide(p10, s);

        alt_q = clip48(hp + qmult(k0, y));
        vel_q = clip48(vp + qmult(k1, y));

        omk = clip48(acc_t'(ONE_Q24) - k0);
        c00 = qmult(omk, p00);
        c01 = qmult(omk, p01);
        c10 = clip48(p10 - qmult(k1, p00));
        c11 = clip48(p11 - qmult(k1, p01));

        e.altitude = to_q12(alt_q);
        e.velocity = to_q12(vel_q);
        e.saturated = clipped;
        return e;
    endfunction

    // Track configuration, predict on each accepted input item, check results.
    always @(posedge aclk) begin
        estimate_t want;
        int        errs;
        errs = 0;
        if (!aresetn) begin
            alt_q <= 0;
            vel_q <= 0;
            c00 <= acc_t'(TEN_Q24);
            c01 <= 0;
            c10 <= 0;
            c11 <= acc_t'(TEN_Q24);
            meas_noise <= R_RESET;
            proc_noise <= Q_RESET;
            estimate_fifo.delete();
            fail_count <= 0;
            pending <= 0;
        end else begin
            if (cfg_wr_en) begin
                if (cfg_addr == CFG_MEAS_NOISE) meas_noise <= cfg_wdata;
                else if (cfg_addr == CFG_PROC_NOISE) proc_noise <= cfg_wdata;
            end
            if (s_tvalid && s_tready)
                estimate_fifo.push_back(predict_correct(s_tdata[31:0], s_tdata[51:32]));
            if (m_tvalid && m_tready) begin
                if (estimate_fifo.size() == 0) begin
                    $display("%0t: unexpected result item alt=%h vel=%h sat=%b",
                             $time, m_tdata[31:0], m_tdata[63:32], m_tuser[0]);
                    errs = errs + 1;
                end else begin
                    want = estimate_fifo.pop_front();
                    if (m_tdata[31:0] !== want.altitude) begin
                        $display("%0t: altitude expected %h actual %h",
                                 $time, want.altitude, m_tdata[31:0]);
                        errs = errs + 1;
                    end
                    if (m_tdata[63:32] !== want.velocity) begin
                        $display("%0t: velocity expected %h actual %h",
                                 $time, want.velocity, m_tdata[63:32]);
                        errs = errs + 1;
                    end
                    if (m_tuser[0] !== want.saturated) begin
                        $display("%0t: saturated expected %b actual %b",
                                 $time, want.saturated, m_tuser[0]);
                        errs = errs + 1;
                    end
                end
            end
            fail_count <= fail_count + errs;
            pending <= estimate_fifo.size();
        end
    end

endmodule

@@ test/testbench.sv @@
// Top of the altitude Kalman filter testbench: clock, reset, stimulus and verdict.
// Depends on akf_pkg, the altitude_kalman_filter_unit RTL and akf_scoreboard.
module testbench;
    import akf_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int SETTLE = 400;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_addr = CFG_MEAS_NOISE;
    logic [31:0] cfg_wdata = '0;
    int          fail_count;
    int          pending;
    int          cycles = 0;
    int          samples_sent = 0;
    int          noise_settings = 0;
    logic        quiet_sender = 1'b0;
    logic        quiet_receiver = 1'b0;

    altitude_kalman_filter_unit u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    akf_scoreboard u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .fail_count(fail_count), .pending(pending)
    );

    // Clock, period 8.
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic int idle_gap(logic quiet);
        if (quiet) return 0;
        return $urandom_range(0, 13);
    endfunction

    // Result side: random stalls per item, with quiet stretches.
    initial begin
        int gap;
        @(posedge aclk iff aresetn);
        forever begin
            if ($urandom_range(0, 49) == 0) quiet_receiver = ~quiet_receiver;
            gap = idle_gap(quiet_receiver);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    // Offer one input item after a random gap and hold it until accepted.
    task automatic send_sample(logic [31:0] altitude, logic [19:0] step);
        int gap;
        if ($urandom_range(0, 49) == 0) quiet_sender = ~quiet_sender;
        gap = idle_gap(quiet_sender);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata <= {4'd0, step, altitude};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        samples_sent++;
    endtask

    // Let every expected result arrive, then give the block time to fall idle.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_noise(logic [31:0] r_val, logic [31:0] q_val);
        cfg_wr_en <= 1'b1;
        cfg_addr <= CFG_MEAS_NOISE;
        cfg_wdata <= r_val;
        @(posedge aclk);
        cfg_addr <= CFG_PROC_NOISE;
        cfg_wdata <= q_val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        noise_settings++;
    endtask

    // Mostly a smooth climb or descent with sensor noise, sometimes raw noise.
    task automatic random_samples(int count);
        int   alt_m, vel_m;
        logic [19:0] step;
        alt_m = $urandom_range(0, 40000) - 1000;
        vel_m = $urandom_range(0, 400) - 200;
        repeat (count) begin
            case ($urandom_range(0, 9))
                0: step = 20'($urandom);
                1: step = 20'd0;
                default: step = $urandom_range(300, 7000);
            endcase
            if ($urandom_range(0, 9) < 7) begin
                alt_m += (vel_m * int'(step)) / 65536;
                if ($urandom_range(0, 19) == 0) vel_m = $urandom_range(0, 400) - 200;
                send_sample((alt_m <<< 12) + $urandom_range(0, 16383) - 8192, step);
            end else begin
                send_sample($urandom, step);
            end
        end
    endtask

    initial begin
        logic [31:0] r_set[7];
        logic [31:0] q_set[7];
        r_set = '{R_RESET, 32'd0, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'd1, 32'd0};
        q_set = '{Q_RESET, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'd1, 32'd0};
        r_set[6] = $urandom;
        q_set[6] = $urandom;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: field extremes under the reset noise settings.
        write_noise(R_RESET, Q_RESET);
        send_sample(32'd0, 20'd0);
        send_sample(32'h7FFF_FFFF, 20'hFFFFF);
        send_sample(32'h8000_0000, 20'hFFFFF);
        send_sample(32'hFFFF_FFFF, 20'd1);
        send_sample(32'h7FFF_FFFF, 20'd0);
        send_sample(32'h8000_0000, 20'd1);
        send_sample(32'h0000_1000, 20'h0028F);
        send_sample(32'h5555_5555, 20'hAAAAA);
        send_sample(32'hAAAA_AAAA, 20'h55555);
        drain();

        // Directed: no noise at all drives the covariance, and so the divisor, to zero.
        write_noise(32'd0, 32'd0);
        repeat (3) send_sample(32'h0001_0000, 20'd0);
        repeat (3) send_sample(32'd0, 20'd0);
        drain();

        // Directed: largest noise values push intermediate terms into clipping.
        write_noise(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_sample(32'h7FFF_FFFF, 20'hFFFFF);
        send_sample(32'h8000_0000, 20'hFFFFF);
        send_sample(32'h1234_5678, 20'h10000);
        drain();

        // Random phases, one per noise setting.
        for (int p = 0; p < 7; p++) begin
            write_noise(r_set[p], q_set[p]);
            random_samples(200);
            drain();
        end

        $display("Sent %0d samples across %0d noise settings, extremes included,",
                 samples_sent, noise_settings);
        $display("with random stalls on both channels.");
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
